// ----- src/assert_macros.svh -----
// Assertion helpers for the RTL; empty in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

// ----- src/scd_pkg.sv -----
package scd_pkg;

  // Number of table entries; codes at or above this give no character or action.
  localparam int unsigned KeyCount = 89;

  // Scan codes with a fixed meaning
  localparam logic [7:0] CodeCaps     = 8'h3A;
  localparam logic [7:0] CodeLShiftDn = 8'h2A;
  localparam logic [7:0] CodeRShiftDn = 8'h36;
  localparam logic [7:0] CodeLShiftUp = 8'hAA;
  localparam logic [7:0] CodeRShiftUp = 8'hB6;
  localparam logic [7:0] CodeCtrlDn   = 8'h1D;
  localparam logic [7:0] CodeCtrlUp   = 8'h9D;
  localparam logic [7:0] CodeAltDn    = 8'h38;
  localparam logic [7:0] CodeAltUp    = 8'hB8;
  localparam logic [7:0] CodeBksp     = 8'h0E;
  localparam logic [7:0] CodeF1       = 8'h3B;
  localparam logic [7:0] CodeF3       = 8'h3D;

  // Characters
  localparam logic [7:0] CharBs     = 8'h08;
  localparam logic [7:0] CharUpperL = 8'h4C;
  localparam logic [7:0] CharLowerL = 8'h6C;
  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperZ = 8'h5A;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharLowerZ = 8'h7A;
  localparam logic [7:0] CaseGap    = 8'd32;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_CHAR  = 3'd1,
    ACT_BKSP  = 3'd2,
    ACT_CLEAR = 3'd3,
    ACT_TERM  = 3'd4
  } act_t;

  typedef struct packed {
    logic       shift_held;
    logic       ctrl_held;
    logic       alt_held;
    logic       caps_on;
    logic [1:0] terminal_shown;
  } flags_t;

  typedef logic [7:0] key_map_t [0:KeyCount-1];

  localparam key_map_t PlainMap = '{
    8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h00, 8'h00,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B,
    8'h6C, 8'h3B, 8'h27, 8'h60, 8'h00, 8'h5C,
    8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D, 8'h2C,
    8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h37, 8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B,
    8'h31, 8'h32, 8'h33, 8'h30, 8'h2E,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  localparam key_map_t UpperMap = '{
    8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h00, 8'h00,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B,
    8'h4C, 8'h3A, 8'h22, 8'h7E, 8'h00, 8'h7C,
    8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D, 8'h3C,
    8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h37, 8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B,
    8'h31, 8'h32, 8'h33, 8'h30, 8'h2E,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

endpackage

// ----- src/scd_decode.sv -----
module scd_decode (
  input  logic [7:0]           code,
  input  scd_pkg::flags_t      flags_cur,
  output logic [7:0]           char_out,
  output scd_pkg::act_t        act_out,
  output scd_pkg::flags_t      flags_next
);

  logic [7:0] key_char;
  logic [7:0] cased_char;
  logic [7:0] term_diff;
  logic       in_table;

  // Update modifier flags from the code
  always_comb begin
    flags_next = flags_cur;
    case (code)
      scd_pkg::CodeCaps:     flags_next.caps_on    = ~flags_cur.caps_on;
      scd_pkg::CodeLShiftDn: flags_next.shift_held = 1'b1;
      scd_pkg::CodeRShiftDn: flags_next.shift_held = 1'b1;
      scd_pkg::CodeLShiftUp: flags_next.shift_held = 1'b0;
      scd_pkg::CodeRShiftUp: flags_next.shift_held = 1'b0;
      scd_pkg::CodeCtrlDn:   flags_next.ctrl_held  = 1'b1;
      scd_pkg::CodeCtrlUp:   flags_next.ctrl_held  = 1'b0;
      scd_pkg::CodeAltDn:    flags_next.alt_held   = 1'b1;
      scd_pkg::CodeAltUp:    flags_next.alt_held   = 1'b0;
      default:               flags_next = flags_cur;
    endcase
    // F1..F3 with alt held picks the shown terminal
    if (flags_next.alt_held && (code >= scd_pkg::CodeF1) && (code <= scd_pkg::CodeF3)) begin
      flags_next.terminal_shown = term_diff[1:0];
    end
  end

  assign term_diff = code - scd_pkg::CodeF1;
  assign in_table  = (code < 8'(scd_pkg::KeyCount));

  // Look up the key with the updated shift state
  always_comb begin
    key_char = 8'h00;
    if (in_table) begin
      key_char = flags_next.shift_held ? scd_pkg::UpperMap[code[6:0]]
                                       : scd_pkg::PlainMap[code[6:0]];
    end
  end

  // Flip letter case under caps lock
  always_comb begin
    cased_char = key_char;
    if (flags_next.caps_on) begin
      if (key_char inside {[scd_pkg::CharUpperA:scd_pkg::CharUpperZ]}) begin
        cased_char = key_char + scd_pkg::CaseGap;
      end else if (key_char inside {[scd_pkg::CharLowerA:scd_pkg::CharLowerZ]}) begin
        cased_char = key_char - scd_pkg::CaseGap;
      end
    end
  end

  // Pick the action in priority order
  always_comb begin
    char_out = 8'h00;
    act_out  = scd_pkg::ACT_NONE;
    if (code == scd_pkg::CodeBksp) begin
      char_out = scd_pkg::CharBs;
      act_out  = scd_pkg::ACT_BKSP;
    end else if (!in_table) begin
      act_out = scd_pkg::ACT_NONE;
    end else if (flags_next.ctrl_held &&
                 ((key_char == scd_pkg::CharUpperL) || (key_char == scd_pkg::CharLowerL))) begin
      act_out = scd_pkg::ACT_CLEAR;
    end else if (flags_next.alt_held && (code >= scd_pkg::CodeF1) &&
                 (code <= scd_pkg::CodeF3)) begin
      act_out = scd_pkg::ACT_TERM;
    end else if (cased_char != 8'h00) begin
      char_out = cased_char;
      act_out  = scd_pkg::ACT_CHAR;
    end
  end

endmodule

// ----- src/scan_code_to_ascii_decoder.sv -----
// Channel  | Handshake                  | Payload
// ---------+----------------------------+-------------------------------------
// input    | in_valid / in_stall        | scan_code[7:0]
// output   | out_valid / out_stall      | char_code[7:0], action[2:0],
//          |                            | shown_terminal[1:0]
//
// One item per cycle sustained while out_stall is low; each item goes from the
// input register through the table lookup into the output register.
// The modifier flags and shown terminal update as an item leaves the input register.
// rst clears both valid bits, the modifier flags and the terminal flag (terminal 0).
// out_stall holds the output register, which then backs up the input register.
module scan_code_to_ascii_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] scan_code,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] char_code,
  output logic [2:0] action,
  output logic [1:0] shown_terminal
);

  `include "assert_macros.svh"

  logic              s1_valid;
  logic [7:0]        s1_code;
  scd_pkg::flags_t   flags;
  scd_pkg::flags_t   dec_flags;
  logic [7:0]        dec_char;
  scd_pkg::act_t     dec_act;
  scd_pkg::act_t     out_act;
  logic              s2_ready;
  logic              s2_load;

  assign s2_ready = !out_valid || !out_stall;
  assign s2_load  = s1_valid && s2_ready;
  assign in_stall = s1_valid && !s2_ready;

  // Capture the input item
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_code <= scan_code;
    end
  end

  scd_decode u_decode (
    .code       (s1_code),
    .flags_cur  (flags),
    .char_out   (dec_char),
    .act_out    (dec_act),
    .flags_next (dec_flags)
  );

  // Advance the keyboard state as an item is decoded
  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (s2_load) begin
      flags <= dec_flags;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      char_code      <= dec_char;
      out_act        <= dec_act;
      shown_terminal <= dec_flags.terminal_shown;
    end
  end

  assign action = out_act;

  `ASSERT_NEVER(a_term_range, clk, rst, flags.terminal_shown == 2'd3, "terminal index out of range")
  `ASSERT_PROP(a_char_only_with_text, clk, rst, (out_valid && (char_code != 8'h00)) |-> ((out_act == scd_pkg::ACT_CHAR) || (out_act == scd_pkg::ACT_BKSP)), "character without text action")
  `ASSERT_PROP(a_term_only_on_switch, clk, rst, !(s2_load && (dec_act == scd_pkg::ACT_TERM)) |=> $stable(flags.terminal_shown), "terminal changed without switch")
  `ASSERT_PROP(a_load_gives_result, clk, rst, s2_load |=> (out_valid && (shown_terminal == flags.terminal_shown)), "decoded item lost or terminal mismatch")

endmodule
